>>> hdl/brf_pkg.sv
// shared types and constants for the banked register file
// operation codes, mode codes, bank lookup result and physical index layout
// no dependencies
`default_nettype none

package brf_pkg;

  // operation codes carried in the input tuser
  typedef enum logic [2:0] {
    OP_READ_REG   = 3'd0,
    OP_WRITE_REG  = 3'd1,
    OP_WRITE_SPSR = 3'd2,
    OP_READ_SPSR  = 3'd3,
    OP_LOAD_SPSR  = 3'd4,
    OP_WRITE_CPSR = 3'd5
  } brf_op_t;

  // processor mode codes (status word bits 4..0)
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  localparam int          STATE_BIT     = 5;
  localparam logic [31:0] ARM_PC_MASK   = 32'hFFFF_FFFC;
  localparam logic [31:0] THUMB_PC_MASK = 32'hFFFF_FFFE;
  localparam logic [31:0] CPSR_RESET    = 32'h0000_00D3;

  // physical register layout: common r0-r15, fiq r8-r14, then r13/r14 of
  // svc, abt, irq, und
  localparam int          NUM_PHYS   = 31;
  localparam logic [4:0]  FIQ_BASE   = 5'd16;
  localparam logic [4:0]  PRIV_BASE  = 5'd23;
  localparam logic [3:0]  PC_REG_NUM = 4'd15;
  localparam int          NUM_SPSR   = 5;

  // saved status word slots
  localparam logic [2:0] SPSR_FIQ = 3'd0;
  localparam logic [2:0] SPSR_SVC = 3'd1;
  localparam logic [2:0] SPSR_ABT = 3'd2;
  localparam logic [2:0] SPSR_IRQ = 3'd3;
  localparam logic [2:0] SPSR_UND = 3'd4;

  // bank lookup result handed from the mapper to the execute unit
  typedef struct packed {
    logic       reg_ok;
    logic [4:0] reg_addr;
    logic       spsr_ok;
    logic [2:0] spsr_addr;
  } brf_map_t;

endpackage

`default_nettype wire

>>> hdl/banked_register_file_core.sv
// top level of the banked register file: input beat register, execute unit
// and result register on stream channels
// depends on brf_pkg and brf_exec
`default_nettype none

// Banked processor register file with mode banking. Each input beat carries
// one operation (read/write a register, write/read the saved status word,
// load the saved status word into the status word, write the status word)
// and produces exactly one result beat with the value read and the status
// word after the operation. One beat is accepted per clock cycle while the
// output is not stalled; each beat sits in the input register for bank decode
// and register access, then its result lands in the result register.
// Each operation updates state in the same cycle it executes, so the next beat
// always sees the result of the previous one. Reset clears all registers and
// saved status words and puts the status word in supervisor mode, ARM state,
// with IRQ and FIQ masked.

module banked_register_file_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // reg_index[3:0], write_data[35:4], use_given_mode[36], given_mode[41:37], zero
  input  wire logic [47:0] s_tdata,
  // operation[2:0]
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // read_data[31:0], status_word[63:32]
  output logic [63:0]      m_tdata
);
  import brf_pkg::*;

  logic        in_valid;
  brf_op_t     in_op;
  logic [3:0]  in_reg_index;
  logic [31:0] in_write_data;
  logic        in_use_given;
  logic [4:0]  in_given_mode;

  logic        advance;
  logic        exec_en;
  logic [31:0] read_data;
  logic [31:0] status_word;

  assign advance  = !m_tvalid || m_tready;
  assign exec_en  = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op         <= brf_op_t'(s_tuser);
      in_reg_index  <= s_tdata[3:0];
      in_write_data <= s_tdata[35:4];
      in_use_given  <= s_tdata[36];
      in_given_mode <= s_tdata[41:37];
    end
  end

  brf_exec u_exec (
    .clk            (clk),
    .rst            (rst),
    .exec_en        (exec_en),
    .operation      (in_op),
    .reg_index      (in_reg_index),
    .write_data     (in_write_data),
    .use_given_mode (in_use_given),
    .given_mode     (in_given_mode),
    .read_data      (read_data),
    .status_word    (status_word)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      m_tdata <= {status_word, read_data};
    end
  end

  // a blocked input beat stays in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("input beat lost while output stalled");

  // a result is shown only when an operation executed or one is pending
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !exec_en |=> !m_tvalid)
    else $error("result beat repeated");

  // every executed operation yields a result beat next cycle
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    exec_en |=> m_tvalid)
    else $error("executed operation produced no result");

endmodule

`default_nettype wire

>>> hdl/brf_bank_map.sv
// mode banking decode: register number and mode to physical register slot,
// current mode to saved status word slot
// depends on brf_pkg
`default_nettype none

module brf_bank_map (
  input  wire logic [3:0]        reg_index,
  input  wire logic [4:0]        reg_mode,
  input  wire logic [4:0]        cur_mode,
  output brf_pkg::brf_map_t      map
);
  import brf_pkg::*;

  logic [1:0] priv_bank;
  logic       priv_ok;
  logic       hi_link;

  assign hi_link = (reg_index == 4'd13) || (reg_index == 4'd14);

  // privileged modes that bank only r13/r14
  always_comb begin
    priv_ok   = 1'b1;
    priv_bank = 2'd0;
    case (reg_mode)
      MODE_SVC: priv_bank = 2'd0;
      MODE_ABT: priv_bank = 2'd1;
      MODE_IRQ: priv_bank = 2'd2;
      MODE_UND: priv_bank = 2'd3;
      default:  priv_ok   = 1'b0;
    endcase
  end

  // register slot
  always_comb begin
    map.reg_ok   = 1'b1;
    map.reg_addr = {1'b0, reg_index};
    if (reg_mode == MODE_USR || reg_mode == MODE_SYS) begin
      map.reg_addr = {1'b0, reg_index};
    end else if (reg_mode == MODE_FIQ) begin
      if (reg_index >= 4'd8 && reg_index <= 4'd14) begin
        map.reg_addr = FIQ_BASE + {1'b0, reg_index} - 5'd8;
      end
    end else if (priv_ok) begin
      if (hi_link) begin
        map.reg_addr = PRIV_BASE + {2'b0, priv_bank, 1'b0} + {4'b0, reg_index[0] ^ 1'b1};
      end
    end else begin
      map.reg_ok = 1'b0;
    end
  end

  // saved status word slot, always by current mode
  always_comb begin
    map.spsr_ok   = 1'b1;
    map.spsr_addr = SPSR_FIQ;
    case (cur_mode)
      MODE_FIQ: map.spsr_addr = SPSR_FIQ;
      MODE_SVC: map.spsr_addr = SPSR_SVC;
      MODE_ABT: map.spsr_addr = SPSR_ABT;
      MODE_IRQ: map.spsr_addr = SPSR_IRQ;
      MODE_UND: map.spsr_addr = SPSR_UND;
      default:  map.spsr_ok   = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/brf_exec.sv
// register storage, saved status words and program status word, with the
// operation logic that reads and updates them
// depends on brf_pkg and brf_bank_map
`default_nettype none

module brf_exec (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              exec_en,
  input  wire brf_pkg::brf_op_t  operation,
  input  wire logic [3:0]        reg_index,
  input  wire logic [31:0]       write_data,
  input  wire logic              use_given_mode,
  input  wire logic [4:0]        given_mode,
  output logic [31:0]            read_data,
  output logic [31:0]            status_word
);
  import brf_pkg::*;

  logic [31:0] regs [NUM_PHYS];
  logic [31:0] spsr [NUM_SPSR];
  logic [31:0] cpsr;
  logic [31:0] cpsr_next;

  logic [4:0]  cur_mode;
  logic [4:0]  reg_mode;
  brf_map_t    map;
  logic [31:0] reg_wdata;
  logic        reg_we;
  logic        spsr_we;

  assign cur_mode = cpsr[4:0];
  assign reg_mode = use_given_mode ? given_mode : cur_mode;

  brf_bank_map u_map (
    .reg_index (reg_index),
    .reg_mode  (reg_mode),
    .cur_mode  (cur_mode),
    .map       (map)
  );

  // pc writes drop to a word or halfword boundary
  always_comb begin
    reg_wdata = write_data;
    if (reg_index == PC_REG_NUM) begin
      reg_wdata = write_data & (cpsr[STATE_BIT] ? THUMB_PC_MASK : ARM_PC_MASK);
    end
  end

  // operation decode
  always_comb begin
    read_data = '0;
    cpsr_next = cpsr;
    reg_we    = 1'b0;
    spsr_we   = 1'b0;
    case (operation)
      OP_READ_REG: begin
        if (map.reg_ok) read_data = regs[map.reg_addr];
      end
      OP_WRITE_REG: begin
        reg_we = map.reg_ok;
      end
      OP_WRITE_SPSR: begin
        spsr_we = map.spsr_ok;
      end
      OP_READ_SPSR: begin
        read_data = map.spsr_ok ? spsr[map.spsr_addr] : cpsr;
      end
      OP_LOAD_SPSR: begin
        if (map.spsr_ok) cpsr_next = spsr[map.spsr_addr];
      end
      OP_WRITE_CPSR: begin
        cpsr_next = write_data;
      end
      default: begin
        read_data = '0;
      end
    endcase
  end

  assign status_word = cpsr_next;

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PHYS; i++) regs[i] <= '0;
      for (int i = 0; i < NUM_SPSR; i++) spsr[i] <= '0;
      cpsr <= CPSR_RESET;
    end else if (exec_en) begin
      if (reg_we) regs[map.reg_addr] <= reg_wdata;
      if (spsr_we) spsr[map.spsr_addr] <= write_data;
      cpsr <= cpsr_next;
    end
  end

  // status word comes out of reset in supervisor mode, arm state, masked
  a_cpsr_reset: assert property (@(posedge clk) rst |=> cpsr == CPSR_RESET)
    else $error("status word not at reset value after reset");

  // the shared pc never holds an odd address
  a_pc_aligned: assert property (@(posedge clk) disable iff (rst)
    regs[PC_REG_NUM][0] == 1'b0)
    else $error("pc holds an unaligned value");

  // only a status word operation may change the status word
  a_cpsr_hold: assert property (@(posedge clk) disable iff (rst)
    !(exec_en && (operation == OP_LOAD_SPSR || operation == OP_WRITE_CPSR))
    |=> $stable(cpsr))
    else $error("status word changed without a status operation");

  // the fiq, svc and und saved status words change only on a saved status write
  a_spsr_hold: assert property (@(posedge clk) disable iff (rst)
    !(exec_en && operation == OP_WRITE_SPSR) |=> $stable(spsr[SPSR_FIQ])
      && $stable(spsr[SPSR_SVC]) && $stable(spsr[SPSR_UND]))
    else $error("saved status word changed without a write");

endmodule

`default_nettype wire

>>> dv/banked_register_file_core_tb.sv
// self-checking testbench for banked_register_file_core: directed and random
// operation beats checked against an in-bench model of the banked register file
// depends on brf_pkg and the banked_register_file_core rtl

module banked_register_file_core_tb;
  import brf_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 8;

  // operation codes with no effect, not part of the package enum
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  // laid out as on m_tdata: read_data low, status_word high
  typedef struct packed {
    logic [31:0] status_word;
    logic [31:0] read_data;
  } rf_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [63:0] m_tdata;

  // model state: common r0-r15, fiq r8-r14, r13/r14 of svc, abt, irq, und
  logic [31:0] phys_model [0:30];
  logic [31:0] spsr_model [0:4];
  logic [31:0] cpsr_model;

  rf_result_t pending_results [$];
  int         mismatch_count = 0;
  int         beats_sent     = 0;
  int         results_seen   = 0;
  int         cycle_count    = 0;
  int         rx_hold_cycles = 0;
  logic       no_idle        = 1'b0;

  banked_register_file_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // physical slot of a register in a mode, -1 for an invalid mode
  function automatic int reg_slot(input logic [3:0] idx, input logic [4:0] mode);
    int b;
    b = -1;
    if (mode == MODE_USR || mode == MODE_SYS) return idx;
    if (mode == MODE_FIQ) return (idx >= 8 && idx <= 14) ? 16 + idx - 8 : idx;
    case (mode)
      MODE_SVC: b = 0;
      MODE_ABT: b = 1;
      MODE_IRQ: b = 2;
      MODE_UND: b = 3;
      default:  b = -1;
    endcase
    if (b < 0) return -1;
    if (idx == 13 || idx == 14) return 23 + b * 2 + (idx - 13);
    return idx;
  endfunction

  // saved status slot of a mode, -1 when the mode has none
  function automatic int spsr_slot(input logic [4:0] mode);
    case (mode)
      MODE_FIQ: return 0;
      MODE_SVC: return 1;
      MODE_ABT: return 2;
      MODE_IRQ: return 3;
      MODE_UND: return 4;
      default:  return -1;
    endcase
  endfunction

  // apply one operation to the model and return the expected result
  function automatic rf_result_t step_reg_file(input logic [2:0] op, input logic [3:0] idx,
                                               input logic [31:0] data, input logic given,
                                               input logic [4:0] gmode);
    logic [4:0]  cur_mode;
    logic [4:0]  sel_mode;
    logic [31:0] wdata;
    int          slot;
    rf_result_t  r;
    cur_mode    = cpsr_model[4:0];
    sel_mode    = given ? gmode : cur_mode;
    wdata       = data;
    r.read_data = '0;
    case (op)
      OP_READ_REG: begin
        slot = reg_slot(idx, sel_mode);
        if (slot >= 0) r.read_data = phys_model[slot];
      end
      OP_WRITE_REG: begin
        if (idx == PC_REG_NUM) wdata &= cpsr_model[STATE_BIT] ? THUMB_PC_MASK : ARM_PC_MASK;
        slot = reg_slot(idx, sel_mode);
        if (slot >= 0) phys_model[slot] = wdata;
      end
      OP_WRITE_SPSR: begin
        slot = spsr_slot(cur_mode);
        if (slot >= 0) spsr_model[slot] = data;
      end
      OP_READ_SPSR: begin
        slot = spsr_slot(cur_mode);
        r.read_data = (slot >= 0) ? spsr_model[slot] : cpsr_model;
      end
      OP_LOAD_SPSR: begin
        slot = spsr_slot(cur_mode);
        if (slot >= 0) cpsr_model = spsr_model[slot];
      end
      OP_WRITE_CPSR: cpsr_model = data;
      default: ;
    endcase
    r.status_word = cpsr_model;
    return r;
  endfunction

  // mostly a legal mode code, sometimes any five-bit value
  function automatic logic [4:0] pick_mode();
    logic [4:0] m;
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 6))
        0:       m = MODE_USR;
        1:       m = MODE_FIQ;
        2:       m = MODE_IRQ;
        3:       m = MODE_SVC;
        4:       m = MODE_ABT;
        5:       m = MODE_UND;
        default: m = MODE_SYS;
      endcase
    end else begin
      m = 5'($urandom_range(0, 31));
    end
    return m;
  endfunction

  // offer one beat after a random gap and log its expected result on accept
  task automatic send_beat(input logic [2:0] op, input logic [3:0] idx,
                           input logic [31:0] data, input logic given,
                           input logic [4:0] gmode);
    int   gap;
    logic acc;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, gmode, given, data, idx};
    do begin
      @(negedge clk);
      acc = s_tready;
      @(posedge clk);
    end while (!acc);
    pending_results.push_back(step_reg_file(op, idx, data, given, gmode));
    beats_sent++;
  endtask

  // compare one result beat with the oldest expectation
  task automatic check_result(input logic [63:0] beat);
    rf_result_t exp_r;
    rf_result_t got_r;
    got_r = beat;
    results_seen++;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing expected, got read_data %h status_word %h",
               $time, got_r.read_data, got_r.status_word);
      mismatch_count++;
    end else begin
      exp_r = pending_results.pop_front();
      if (got_r.read_data !== exp_r.read_data) begin
        $display("%0t: read_data mismatch, expected %h, got %h",
                 $time, exp_r.read_data, got_r.read_data);
        mismatch_count++;
      end
      if (got_r.status_word !== exp_r.status_word) begin
        $display("%0t: status_word mismatch, expected %h, got %h",
                 $time, exp_r.status_word, got_r.status_word);
        mismatch_count++;
      end
    end
  endtask

  // receive side: random stalls, optional long hold-off
  initial begin : rx_side
    int          stall;
    logic        got;
    logic [63:0] beat;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        m_tready <= 1'b1;
      end
      do begin
        @(negedge clk);
        got  = m_tvalid;
        beat = m_tdata;
        @(posedge clk);
      end while (!got);
      check_result(beat);
    end
  end

  // state straight out of reset
  task automatic test_reset_values();
    send_beat(OP_READ_REG, 4'd13, 32'h0, 1'b0, 5'h00);
    send_beat(OP_READ_SPSR, 4'd0, 32'h0, 1'b0, 5'h00);
  endtask

  // pc write alignment in arm and thumb state, pc shared across modes
  task automatic test_pc_alignment();
    send_beat(OP_WRITE_REG, PC_REG_NUM, 32'hFFFF_FFFF, 1'b0, 5'h00);
    send_beat(OP_READ_REG, PC_REG_NUM, 32'h0, 1'b0, 5'h00);
    send_beat(OP_WRITE_CPSR, 4'd0, 32'h0000_0033, 1'b0, 5'h00);
    send_beat(OP_WRITE_REG, PC_REG_NUM, 32'hFFFF_FFFF, 1'b0, 5'h00);
    send_beat(OP_READ_REG, PC_REG_NUM, 32'h0, 1'b1, MODE_USR);
  endtask

  // fiq and privileged banks kept apart from the common set
  task automatic test_mode_banking();
    send_beat(OP_WRITE_REG, 4'd14, 32'hAAAA_AAAA, 1'b0, 5'h00);
    send_beat(OP_WRITE_REG, 4'd14, 32'h5555_5555, 1'b1, MODE_FIQ);
    send_beat(OP_WRITE_REG, 4'd8, 32'h1234_5678, 1'b1, MODE_FIQ);
    send_beat(OP_READ_REG, 4'd14, 32'h0, 1'b1, MODE_USR);
    send_beat(OP_READ_REG, 4'd14, 32'h0, 1'b1, MODE_FIQ);
    send_beat(OP_READ_REG, 4'd8, 32'h0, 1'b1, MODE_SYS);
  endtask

  // spsr write/read/load, then the same ops in a mode with no spsr
  task automatic test_saved_status();
    send_beat(OP_WRITE_SPSR, 4'd0, 32'hF000_003F, 1'b1, 5'h00);
    send_beat(OP_READ_SPSR, 4'd0, 32'h0, 1'b0, 5'h00);
    send_beat(OP_LOAD_SPSR, 4'd0, 32'h0, 1'b0, 5'h00);
    send_beat(OP_READ_SPSR, 4'd0, 32'h0, 1'b0, 5'h00);
    send_beat(OP_WRITE_SPSR, 4'd0, 32'hFFFF_FFFF, 1'b0, 5'h00);
    send_beat(OP_LOAD_SPSR, 4'd0, 32'h0, 1'b0, 5'h00);
  endtask

  // invalid current and given modes, unused operation codes
  task automatic test_invalid_modes();
    send_beat(OP_WRITE_CPSR, 4'd0, 32'h0000_0000, 1'b0, 5'h00);
    send_beat(OP_READ_REG, 4'd0, 32'h0, 1'b0, 5'h00);
    send_beat(OP_WRITE_REG, 4'd1, 32'hFFFF_FFFF, 1'b0, 5'h00);
    send_beat(OP_UNUSED_6, 4'd15, 32'hFFFF_FFFF, 1'b1, 5'h1F);
    send_beat(OP_UNUSED_7, 4'd15, 32'hFFFF_FFFF, 1'b1, 5'h1F);
    send_beat(OP_WRITE_CPSR, 4'd0, CPSR_RESET, 1'b0, 5'h00);
    send_beat(OP_READ_REG, 4'd1, 32'h0, 1'b1, 5'h1F);
    send_beat(OP_WRITE_REG, 4'd1, 32'h0BAD_0BAD, 1'b1, 5'h00);
  endtask

  // random operation mix, mostly with legal modes
  task automatic test_random_traffic(input int count);
    int          k;
    int          pick;
    logic [2:0]  op;
    logic [3:0]  idx;
    logic [31:0] data;
    logic        given;
    logic [4:0]  gmode;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      op = OP_READ_REG;
      else if (pick < 60) op = OP_WRITE_REG;
      else if (pick < 68) op = OP_WRITE_SPSR;
      else if (pick < 76) op = OP_READ_SPSR;
      else if (pick < 82) op = OP_LOAD_SPSR;
      else if (pick < 96) op = OP_WRITE_CPSR;
      else if (pick < 98) op = OP_UNUSED_6;
      else                op = OP_UNUSED_7;
      data = $urandom;
      if (op == OP_WRITE_CPSR || op == OP_WRITE_SPSR) data[4:0] = pick_mode();
      idx   = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(8, 15));
      given = 1'($urandom_range(0, 1));
      gmode = pick_mode();
      send_beat(op, idx, data, given, gmode);
    end
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_output_backpressure();
    no_idle        = 1'b1;
    rx_hold_cycles = 200;
    test_random_traffic(30);
    no_idle        = 1'b0;
  endtask

  // no idle cycles on either side
  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_traffic(40);
    no_idle = 1'b0;
  endtask

  initial begin : main_seq
    int i;
    for (i = 0; i < 31; i++) phys_model[i] = '0;
    for (i = 0; i < 5; i++) spsr_model[i] = '0;
    cpsr_model = CPSR_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_pc_alignment();
    test_mode_banking();
    test_saved_status();
    test_invalid_modes();
    test_random_traffic(180);
    test_back_to_back();
    test_output_backpressure();
    test_random_traffic(180);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered reset state, pc alignment, banking, spsr paths, invalid modes,");
    $display("random mix with stalls and a long output hold: %0d beats, %0d results",
             beats_sent, results_seen);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> banked_register_file_core.f
hdl/brf_pkg.sv
hdl/brf_bank_map.sv
hdl/brf_exec.sv
hdl/banked_register_file_core.sv
dv/banked_register_file_core_tb.sv
